>>> sv/slmsc_pkg.sv
package slmsc_pkg;

   // default geometry
   localparam int LANES_DEF      = 32;
   localparam int MASK_DEPTH_DEF = 16;
   localparam int LOOP_DEPTH_DEF = 8;

   // fixed field widths
   localparam int PC_W     = 12;
   localparam int TARGET_W = 13;
   localparam int COND_W   = 32;
   localparam int STATUS_W = 3;
   localparam int LCNT_W   = 6;
   localparam int STEP_W   = 24;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 24;

   localparam logic [TARGET_W-1:0] PROG_SIZE = 13'd4096;

   localparam logic [LCNT_W-1:0] LANE_COUNT_RESET = 6'd32;
   localparam logic [STEP_W-1:0] STEP_LIMIT_RESET = 24'd4000000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LANE_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_LIMIT = 1'b1;

   typedef enum logic [3:0] {
      K_START        = 4'd0,
      K_PLAIN        = 4'd1,
      K_JUMP         = 4'd2,
      K_JUMP_IF_ZERO = 4'd3,
      K_MASK         = 4'd4,
      K_MASK_NOT     = 4'd5,
      K_POP_MASK     = 4'd6,
      K_LOOP         = 4'd7,
      K_LOOP_TEST    = 4'd8,
      K_LOOP_RESTORE = 4'd9,
      K_LOOP_END     = 4'd10,
      K_POP_LOOP     = 4'd11,
      K_BREAK        = 4'd12,
      K_CONTINUE     = 4'd13,
      K_RETURN       = 4'd14
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_NO_LOOP   = 3'd1,
      STAT_OVERFLOW  = 3'd2,
      STAT_UNDERFLOW = 3'd3,
      STAT_RUNAWAY   = 3'd4
   } status_type;

   // how the next pc is chosen once the top mask is known
   typedef enum logic [2:0] {
      PC_SEQ,
      PC_TARGET,
      PC_ZERO,
      PC_END,
      PC_TARGET_IF_ZERO,
      PC_EXIT_IF_ZERO,
      PC_TARGET_ELSE_EXIT
   } pc_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_TOP,
      ST_PUSH,
      ST_LOOP_RD,
      ST_CLR_MASK,
      ST_CLR_BRK,
      ST_CLR_LOOP,
      ST_FINISH
   } state_type;

   function automatic logic [TARGET_W-1:0] clamp_pc(input logic [TARGET_W-1:0] pc);
      return (pc > PROG_SIZE) ? PROG_SIZE : pc;
   endfunction

endpackage

>>> sv/simd_lane_mask_stack_controller.sv
// Lane mask stack controller: takes one control instruction per transaction
// (start & !busy) and answers with one result transaction, marked by
// rsp_strobe for a single cycle; the receiver cannot stall, so the result
// must be captured when the strobe is seen. busy stays high while an
// instruction is in work and no new one is taken. All lane masking runs
// through one lane-wide AND / AND-NOT unit under a small sequencer, one stack
// entry per cycle. Each instruction is decoded first; then mask and loop
// kinds latch the top mask (narrowed by the condition for mask kinds) and
// push it, loop test / restore / end rewrite the innermost loop entry and
// the top mask from it, and break, continue and return latch the top mask
// and strip its lanes from the masks from the loop base up (return: from
// all masks), then break from the innermost loop and return from all loops.
// Errors and the remaining kinds go straight to the result. The strobe is
// registered out of the finish state and busy is already low while it is
// up, so the next instruction can be taken at the same edge as the result.
// Break, continue and return run longer with more entries to clear, as the
// lane unit clears one mask or loop entry per cycle. Config writes take
// effect at any edge; make them only while idle.
module simd_lane_mask_stack_controller
   import slmsc_pkg::*;
#(
   parameter int LANES      = LANES_DEF,
   parameter int MASK_DEPTH = MASK_DEPTH_DEF,
   parameter int LOOP_DEPTH = LOOP_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // instruction
   input  logic                  start,
   output logic                  busy,
   input  logic [3:0]            req_kind,
   input  logic [PC_W-1:0]       req_cur_pc,
   input  logic [TARGET_W-1:0]   req_jump_target,
   input  logic [COND_W-1:0]     req_cond_bits,
   // result
   output logic                  rsp_strobe,
   output logic [TARGET_W-1:0]   rsp_next_pc,
   output logic [COND_W-1:0]     rsp_active_mask,
   output logic                  rsp_any_live,
   output logic [STATUS_W-1:0]   rsp_status,
   // config
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int MCW = $clog2(MASK_DEPTH + 1);           // mask count
   localparam int MIW = $clog2(MASK_DEPTH);               // mask index
   localparam int LCW = $clog2(LOOP_DEPTH + 1);           // loop count
   localparam int LIW = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;
   localparam int PW  = (MCW > LCW) ? MCW : LCW;          // sweep pointer

   // ---------------------------------------------------------------- state
   state_type             state_ff, state_in;
   kind_type              kind_ff, kind_in;
   logic [PC_W-1:0]       pc_ff, pc_in;
   logic [TARGET_W-1:0]   target_ff, target_in;
   logic [LANES-1:0]      cond_ff, cond_in;
   status_type            status_ff, status_in;
   pc_sel_type            pcsel_ff, pcsel_in;
   logic [LANES-1:0]      going_ff, going_in;     // lane unit result register
   logic [PW-1:0]         ptr_ff, ptr_in;
   logic [TARGET_W-1:0]   exit_ff, exit_in;
   logic [MCW-1:0]        mc_ff, mc_in;
   logic [LCW-1:0]        lc_ff, lc_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [LCNT_W-1:0]     lane_count_ff, lane_count_in;
   logic [STEP_W-1:0]     step_limit_ff, step_limit_in;

   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [TARGET_W-1:0]   rsp_next_pc_ff, rsp_next_pc_in;
   logic [COND_W-1:0]     rsp_mask_ff, rsp_mask_in;
   logic                  rsp_live_ff, rsp_live_in;
   status_type            rsp_status_ff, rsp_status_in;

   // stacks
   logic [LANES-1:0]      mask_mem_ff [MASK_DEPTH];
   logic [LANES-1:0]      loop_lane_ff [LOOP_DEPTH];
   logic [MCW-1:0]        loop_base_ff [LOOP_DEPTH];
   logic [TARGET_W-1:0]   loop_exit_ff [LOOP_DEPTH];

   // stack ports
   logic                  mask_we;
   logic [MIW-1:0]        mask_widx, mask_ridx;
   logic [LANES-1:0]      mask_wdata, mask_rdata;
   logic                  loop_we, loop_push;
   logic [LIW-1:0]        loop_widx, loop_ridx;
   logic [LANES-1:0]      loop_wdata, loop_rdata;
   logic [MCW-1:0]        base_rd;
   logic [TARGET_W-1:0]   exit_rd;

   // shared lane unit
   logic [LANES-1:0]      unit_a, unit_b, unit_out;
   logic                  unit_inv;

   // decode helpers
   logic [MCW-1:0]        mc_m1;
   logic [LCW-1:0]        lc_m1;
   logic [MIW-1:0]        top_idx;
   logic [LIW-1:0]        lp;
   logic                  has_loop, mask_full, loop_full, step_out;
   logic                  ptr_in_masks, ptr_in_loops;
   logic [LANES-1:0]      top_mask, full_mask, cond_lanes;
   logic [LCNT_W:0]       lane_n;
   logic [63:0]           cond_wide, top_wide;
   logic [TARGET_W-1:0]   seq_pc, tgt_pc, exit_pc;

   assign mc_m1     = mc_ff - MCW'(1);
   assign lc_m1     = lc_ff - LCW'(1);
   assign top_idx   = mc_m1[MIW-1:0];
   assign lp        = lc_m1[LIW-1:0];
   assign has_loop  = (lc_ff != '0);
   assign mask_full = (mc_ff >= MCW'(MASK_DEPTH));
   assign loop_full = (lc_ff >= LCW'(LOOP_DEPTH));
   assign step_out  = (step_ff >= step_limit_ff);
   assign ptr_in_masks = (ptr_ff < PW'(mc_ff));
   assign ptr_in_loops = (ptr_ff < PW'(lc_ff));

   assign mask_rdata = mask_mem_ff[mask_ridx];
   assign loop_rdata = loop_lane_ff[loop_ridx];
   assign base_rd    = loop_base_ff[lp];
   assign exit_rd    = loop_exit_ff[lp];

   // top of the mask stack reads as zero when the stack is empty
   assign top_mask = (mc_ff != '0) ? mask_rdata : '0;

   assign unit_out = unit_a & (unit_inv ? ~unit_b : unit_b);

   // lanes beyond the condition port read as zero; result shows the low lanes
   assign cond_wide  = 64'(req_cond_bits);
   assign cond_lanes = cond_wide[LANES-1:0];
   assign top_wide   = 64'(top_mask);

   // a lane count of zero acts as one; above LANES all lanes are set
   assign lane_n = (lane_count_ff == '0) ? (LCNT_W+1)'(1) : (LCNT_W+1)'(lane_count_ff);
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         full_mask[i] = (i < int'(lane_n));
      end
   end

   assign seq_pc  = clamp_pc(TARGET_W'(pc_ff) + TARGET_W'(1));
   assign tgt_pc  = clamp_pc(target_ff);
   assign exit_pc = clamp_pc(exit_ff);

   // ------------------------------------------------------------ next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            state_in = ST_FINISH;
            if (kind_ff != K_START && !step_out) begin
               case (kind_ff)
                  K_MASK, K_MASK_NOT: begin
                     if (!mask_full) state_in = ST_TOP;
                  end
                  K_LOOP: begin
                     if (!mask_full && !loop_full) state_in = ST_TOP;
                  end
                  K_LOOP_TEST, K_LOOP_RESTORE, K_LOOP_END: begin
                     if (has_loop) state_in = ST_LOOP_RD;
                  end
                  K_BREAK, K_CONTINUE: begin
                     if (has_loop) state_in = ST_TOP;
                  end
                  K_RETURN: state_in = ST_TOP;
                  default:  state_in = ST_FINISH;
               endcase
            end
         end
         ST_TOP: begin
            if (kind_ff inside {K_MASK, K_MASK_NOT, K_LOOP}) state_in = ST_PUSH;
            else                                             state_in = ST_CLR_MASK;
         end
         ST_PUSH:    state_in = ST_FINISH;
         ST_LOOP_RD: state_in = ST_FINISH;
         ST_CLR_MASK: begin
            if (!ptr_in_masks) begin
               case (kind_ff)
                  K_BREAK:  state_in = ST_CLR_BRK;
                  K_RETURN: state_in = ST_CLR_LOOP;
                  default:  state_in = ST_FINISH;
               endcase
            end
         end
         ST_CLR_BRK: state_in = ST_FINISH;
         ST_CLR_LOOP: begin
            if (!ptr_in_loops) state_in = ST_FINISH;
         end
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------- datapath control
   always_comb begin
      kind_in       = kind_ff;
      pc_in         = pc_ff;
      target_in     = target_ff;
      cond_in       = cond_ff;
      status_in     = status_ff;
      pcsel_in      = pcsel_ff;
      going_in      = going_ff;
      ptr_in        = ptr_ff;
      exit_in       = exit_ff;
      mc_in         = mc_ff;
      lc_in         = lc_ff;
      step_in       = step_ff;
      lane_count_in = lane_count_ff;
      step_limit_in = step_limit_ff;

      rsp_strobe_in  = 1'b0;
      rsp_next_pc_in = rsp_next_pc_ff;
      rsp_mask_in    = rsp_mask_ff;
      rsp_live_in    = rsp_live_ff;
      rsp_status_in  = rsp_status_ff;

      mask_we    = 1'b0;
      mask_widx  = top_idx;
      mask_wdata = unit_out;
      mask_ridx  = top_idx;
      loop_we    = 1'b0;
      loop_push  = 1'b0;
      loop_widx  = lp;
      loop_wdata = unit_out;
      loop_ridx  = lp;
      unit_a     = mask_rdata;
      unit_b     = '1;
      unit_inv   = 1'b0;

      // config port; the user must write it only while idle, the block does not enforce this
      if (csr_write_en) begin
         if (csr_index == CSR_LANE_COUNT) lane_count_in = csr_write_data[LCNT_W-1:0];
         if (csr_index == CSR_STEP_LIMIT) step_limit_in = csr_write_data[STEP_W-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in   = kind_type'(req_kind);
               pc_in     = req_cur_pc;
               target_in = req_jump_target;
               cond_in   = cond_lanes;
               status_in = STAT_OK;
               pcsel_in  = PC_SEQ;
            end
         end

         ST_DECODE: begin
            if (kind_ff == K_START) begin
               mc_in      = MCW'(1);
               lc_in      = '0;
               step_in    = '0;
               mask_we    = 1'b1;
               mask_widx  = '0;
               mask_wdata = full_mask;
               pcsel_in   = PC_ZERO;
            end else if (step_out) begin
               status_in = STAT_RUNAWAY;
               pcsel_in  = PC_END;
            end else begin
               // every counted instruction uses a step, errors included
               step_in = step_ff + STEP_W'(1);
               case (kind_ff)
                  K_JUMP: pcsel_in = PC_TARGET;
                  K_JUMP_IF_ZERO: begin
                     if (!cond_ff[0]) pcsel_in = PC_TARGET;
                  end
                  K_MASK, K_MASK_NOT: begin
                     if (mask_full) status_in = STAT_OVERFLOW;
                     else           pcsel_in  = PC_TARGET_IF_ZERO;
                  end
                  K_POP_MASK: begin
                     if (mc_ff < MCW'(2)) status_in = STAT_UNDERFLOW;
                     else                 mc_in     = mc_m1;
                  end
                  K_LOOP: begin
                     if (mask_full || loop_full) status_in = STAT_OVERFLOW;
                  end
                  K_LOOP_TEST, K_LOOP_RESTORE: begin
                     if (!has_loop) status_in = STAT_UNDERFLOW;
                     else           pcsel_in  = PC_EXIT_IF_ZERO;
                  end
                  K_LOOP_END: begin
                     if (!has_loop) status_in = STAT_UNDERFLOW;
                     else           pcsel_in  = PC_TARGET_ELSE_EXIT;
                  end
                  K_POP_LOOP: begin
                     if (!has_loop || mc_ff < MCW'(2)) begin
                        status_in = STAT_UNDERFLOW;
                     end else begin
                        mc_in = mc_m1;
                        lc_in = lc_m1;
                     end
                  end
                  K_BREAK, K_CONTINUE: begin
                     if (!has_loop) status_in = STAT_NO_LOOP;
                  end
                  default: ;
               endcase
            end
         end

         // latch the top mask, narrowed by the condition for mask kinds
         ST_TOP: begin
            unit_a = top_mask;
            case (kind_ff)
               K_MASK:     unit_b = cond_ff;
               K_MASK_NOT: begin
                  unit_b   = cond_ff;
                  unit_inv = 1'b1;
               end
               default:    unit_b = '1;
            endcase
            going_in = unit_out;
            if (kind_ff == K_RETURN) ptr_in = '0;
            else                     ptr_in = PW'(base_rd);
         end

         ST_PUSH: begin
            mask_we    = 1'b1;
            mask_widx  = mc_ff[MIW-1:0];
            mask_wdata = going_ff;
            mc_in      = mc_ff + MCW'(1);
            if (kind_ff == K_LOOP) begin
               loop_we    = 1'b1;
               loop_push  = 1'b1;
               loop_widx  = lc_ff[LIW-1:0];
               loop_wdata = going_ff;
               lc_in      = lc_ff + LCW'(1);
            end
         end

         // loop lanes (narrowed on a test) become the new top mask
         ST_LOOP_RD: begin
            unit_a     = loop_rdata;
            unit_b     = (kind_ff == K_LOOP_TEST) ? cond_ff : '1;
            loop_we    = 1'b1;
            loop_wdata = unit_out;
            mask_we    = (mc_ff != '0);
            mask_wdata = unit_out;
            exit_in    = exit_rd;
         end

         // strip leaving lanes from the masks, one entry per cycle
         ST_CLR_MASK: begin
            mask_ridx = ptr_ff[MIW-1:0];
            unit_a    = mask_rdata;
            unit_b    = going_ff;
            unit_inv  = 1'b1;
            if (ptr_in_masks) begin
               mask_we    = 1'b1;
               mask_widx  = ptr_ff[MIW-1:0];
               mask_wdata = unit_out;
               ptr_in     = ptr_ff + PW'(1);
            end else begin
               ptr_in = '0;
            end
         end

         ST_CLR_BRK: begin
            unit_a     = loop_rdata;
            unit_b     = going_ff;
            unit_inv   = 1'b1;
            loop_we    = 1'b1;
            loop_wdata = unit_out;
         end

         ST_CLR_LOOP: begin
            loop_ridx = ptr_ff[LIW-1:0];
            unit_a    = loop_rdata;
            unit_b    = going_ff;
            unit_inv  = 1'b1;
            if (ptr_in_loops) begin
               loop_we    = 1'b1;
               loop_widx  = ptr_ff[LIW-1:0];
               loop_wdata = unit_out;
               ptr_in     = ptr_ff + PW'(1);
            end
         end

         ST_FINISH: begin
            rsp_strobe_in = 1'b1;
            rsp_mask_in   = top_wide[COND_W-1:0];
            rsp_live_in   = (top_wide[COND_W-1:0] != '0);
            rsp_status_in = status_ff;
            case (pcsel_ff)
               PC_SEQ:              rsp_next_pc_in = seq_pc;
               PC_TARGET:           rsp_next_pc_in = tgt_pc;
               PC_ZERO:             rsp_next_pc_in = '0;
               PC_END:              rsp_next_pc_in = PROG_SIZE;
               PC_TARGET_IF_ZERO:   rsp_next_pc_in = (top_mask == '0) ? tgt_pc : seq_pc;
               PC_EXIT_IF_ZERO:     rsp_next_pc_in = (top_mask == '0) ? exit_pc : seq_pc;
               PC_TARGET_ELSE_EXIT: rsp_next_pc_in = (top_mask != '0) ? tgt_pc : exit_pc;
               default:             rsp_next_pc_in = seq_pc;
            endcase
         end

         default: ;
      endcase
   end

   // ------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mc_ff         <= '0;
         lc_ff         <= '0;
         step_ff       <= '0;
         lane_count_ff <= LANE_COUNT_RESET;
         step_limit_ff <= STEP_LIMIT_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mc_ff         <= mc_in;
         lc_ff         <= lc_in;
         step_ff       <= step_in;
         lane_count_ff <= lane_count_in;
         step_limit_ff <= step_limit_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      pc_ff          <= pc_in;
      target_ff      <= target_in;
      cond_ff        <= cond_in;
      status_ff      <= status_in;
      pcsel_ff       <= pcsel_in;
      going_ff       <= going_in;
      ptr_ff         <= ptr_in;
      exit_ff        <= exit_in;
      rsp_next_pc_ff <= rsp_next_pc_in;
      rsp_mask_ff    <= rsp_mask_in;
      rsp_live_ff    <= rsp_live_in;
      rsp_status_ff  <= rsp_status_in;
   end

   // stacks: one write per cycle each; entries are read only once written
   always_ff @(posedge clock) begin
      if (mask_we) mask_mem_ff[mask_widx] <= mask_wdata;
      if (loop_we) loop_lane_ff[loop_widx] <= loop_wdata;
      if (loop_push) begin
         loop_base_ff[loop_widx] <= mc_ff;
         loop_exit_ff[loop_widx] <= target_ff;
      end
   end

   // ---------------------------------------------------------------- ports
   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_next_pc     = rsp_next_pc_ff;
   assign rsp_active_mask = rsp_mask_ff;
   assign rsp_any_live    = rsp_live_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

>>> sv/slmsc_checker.sv
module slmsc_checker
   import slmsc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_strobe,
   input logic [TARGET_W-1:0]   rsp_next_pc,
   input logic [COND_W-1:0]     rsp_active_mask,
   input logic                  rsp_any_live,
   input logic [STATUS_W-1:0]   rsp_status
);

   // an accepted transaction keeps the block busy through the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   // result appears only once the block has gone idle again
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy && $past(busy))
      else $error("result strobe while busy or without preceding work");

   // single-cycle strobe, one result per transaction
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   a_live_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_any_live == (rsp_active_mask != '0)))
      else $error("any_live disagrees with active mask");

   a_runaway_pc: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == STAT_RUNAWAY) |-> (rsp_next_pc == PROG_SIZE))
      else $error("runaway result without end-of-program pc");

endmodule

bind simd_lane_mask_stack_controller slmsc_checker u_slmsc_checker (.*);

>>> bench/lane_mask_checker.sv
module lane_mask_checker
   import slmsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [3:0]            req_kind,
   input  logic [PC_W-1:0]       req_cur_pc,
   input  logic [TARGET_W-1:0]   req_jump_target,
   input  logic [COND_W-1:0]     req_cond_bits,
   input  logic                  rsp_strobe,
   input  logic [TARGET_W-1:0]   rsp_next_pc,
   input  logic [COND_W-1:0]     rsp_active_mask,
   input  logic                  rsp_any_live,
   input  logic [STATUS_W-1:0]   rsp_status,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output int                    mismatch_count,
   output int                    pending,
   output int                    checked_count,
   output int                    error_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LANES   = LANES_DEF;
   localparam int MASK_D  = MASK_DEPTH_DEF;
   localparam int LOOP_D  = LOOP_DEPTH_DEF;

   typedef struct packed {
      logic [3:0]          kind;
      logic [TARGET_W-1:0] next_pc;
      logic [COND_W-1:0]   active_mask;
      logic                any_live;
      logic [STATUS_W-1:0] status;
   } ctrl_result_type;

   // shadow of the block's stacks and registers
   logic [COND_W-1:0]   mask_stk   [MASK_D];
   int                  mask_cnt;
   logic [COND_W-1:0]   loop_lanes [LOOP_D];
   int                  loop_base  [LOOP_D];
   logic [TARGET_W-1:0] loop_exit  [LOOP_D];
   int                  loop_cnt;
   int unsigned         steps_done;
   logic [LCNT_W-1:0]   lane_cnt;
   logic [STEP_W-1:0]   step_lim;

   ctrl_result_type expected_results [$];
   ctrl_result_type oldest;

   function automatic logic [COND_W-1:0] start_mask();
      int n = lane_cnt;
      if (n == 0) n = 1;
      if (n >= LANES) return '1;
      return (COND_W'(1) << n) - COND_W'(1);
   endfunction

   function automatic logic [COND_W-1:0] mask_top();
      return (mask_cnt == 0) ? '0 : mask_stk[mask_cnt-1];
   endfunction

   function automatic logic [TARGET_W-1:0] sat_pc(input logic [TARGET_W:0] pc);
      return (pc > PROG_SIZE) ? PROG_SIZE : pc[TARGET_W-1:0];
   endfunction

   function automatic ctrl_result_type predict_control_step(input logic [3:0] kind,
                                                            input logic [PC_W-1:0] pc,
                                                            input logic [TARGET_W-1:0] tgt,
                                                            input logic [COND_W-1:0] cond);
      ctrl_result_type     r;
      logic [TARGET_W-1:0] nxt;
      status_type          st;
      logic [COND_W-1:0]   m;
      logic [COND_W-1:0]   going;
      bit                  has_loop;
      int                  lp;
      nxt      = sat_pc({2'b00, pc} + 14'd1);
      st       = STAT_OK;
      has_loop = (loop_cnt != 0);
      lp       = has_loop ? loop_cnt - 1 : 0;
      if (kind == K_START) begin
         mask_cnt    = 1;
         mask_stk[0] = start_mask();
         loop_cnt    = 0;
         steps_done  = 0;
         nxt         = '0;
      end else if (steps_done >= step_lim) begin
         st  = STAT_RUNAWAY;
         nxt = PROG_SIZE;
      end else begin
         steps_done++;
         case (kind)
            K_JUMP: nxt = sat_pc({1'b0, tgt});
            K_JUMP_IF_ZERO: begin
               if (!cond[0]) nxt = sat_pc({1'b0, tgt});
            end
            K_MASK, K_MASK_NOT: begin
               if (mask_cnt >= MASK_D) st = STAT_OVERFLOW;
               else begin
                  m = mask_top() & ((kind == K_MASK) ? cond : ~cond);
                  mask_stk[mask_cnt] = m;
                  mask_cnt++;
                  if (m == '0) nxt = sat_pc({1'b0, tgt});
               end
            end
            K_POP_MASK: begin
               if (mask_cnt < 2) st = STAT_UNDERFLOW;
               else mask_cnt--;
            end
            K_LOOP: begin
               if (mask_cnt >= MASK_D || loop_cnt >= LOOP_D) st = STAT_OVERFLOW;
               else begin
                  m = mask_top();
                  loop_lanes[loop_cnt] = m;
                  loop_base[loop_cnt]  = mask_cnt;
                  loop_exit[loop_cnt]  = tgt;
                  loop_cnt++;
                  mask_stk[mask_cnt] = m;
                  mask_cnt++;
               end
            end
            K_LOOP_TEST, K_LOOP_RESTORE, K_LOOP_END: begin
               if (!has_loop) st = STAT_UNDERFLOW;
               else begin
                  if (kind == K_LOOP_TEST) loop_lanes[lp] &= cond;
                  if (mask_cnt != 0) mask_stk[mask_cnt-1] = loop_lanes[lp];
                  if (kind == K_LOOP_END)
                     nxt = sat_pc({1'b0, (mask_top() != '0) ? tgt : loop_exit[lp]});
                  else if (mask_top() == '0)
                     nxt = sat_pc({1'b0, loop_exit[lp]});
               end
            end
            K_POP_LOOP: begin
               if (!has_loop || mask_cnt < 2) st = STAT_UNDERFLOW;
               else begin
                  mask_cnt--;
                  loop_cnt--;
               end
            end
            K_BREAK, K_CONTINUE: begin
               if (!has_loop) st = STAT_NO_LOOP;
               else begin
                  going = mask_top();
                  for (int i = loop_base[lp]; i < mask_cnt; i++) mask_stk[i] &= ~going;
                  if (kind == K_BREAK) loop_lanes[lp] &= ~going;
               end
            end
            K_RETURN: begin
               going = mask_top();
               for (int i = 0; i < mask_cnt; i++) mask_stk[i] &= ~going;
               for (int i = 0; i < loop_cnt; i++) loop_lanes[i] &= ~going;
            end
            default: ;  // plain and the unused code
         endcase
      end
      r.kind        = kind;
      r.next_pc     = nxt;
      r.active_mask = mask_top();
      r.any_live    = (mask_top() != '0);
      r.status      = st;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (mask_stk[i]) mask_stk[i] = '0;
         foreach (loop_lanes[i]) begin
            loop_lanes[i] = '0;
            loop_base[i]  = 0;
            loop_exit[i]  = '0;
         end
         mask_cnt   = 0;
         loop_cnt   = 0;
         steps_done = 0;
         lane_cnt   = LANE_COUNT_RESET;
         step_lim   = STEP_LIMIT_RESET;
         expected_results.delete();
         mismatch_count = 0;
         checked_count  = 0;
         error_count    = 0;
         pending <= 0;
      end else begin
         // result first: it belongs to an older transaction than one taken now
         if (rsp_strobe) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result with no transaction outstanding: pc %0d mask %h",
                           $realtime, rsp_next_pc, rsp_active_mask);
            end else begin
               oldest = expected_results.pop_front();
               checked_count++;
               if (oldest.status != STAT_OK) error_count++;
               if (rsp_next_pc !== oldest.next_pc || rsp_active_mask !== oldest.active_mask ||
                   rsp_any_live !== oldest.any_live || rsp_status !== oldest.status) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"%0t: kind %0d: next_pc %0d/%0d mask %h/%h live %b/%b",
                               " status %0d/%0d (expected/actual)"}, $realtime, oldest.kind,
                              oldest.next_pc, rsp_next_pc, oldest.active_mask,
                              rsp_active_mask, oldest.any_live, rsp_any_live,
                              oldest.status, rsp_status);
               end
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_LANE_COUNT: lane_cnt = csr_write_data[LCNT_W-1:0];
               CSR_STEP_LIMIT: step_lim = csr_write_data[STEP_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy)
            expected_results.insert(expected_results.size(),
                                    predict_control_step(req_kind, req_cur_pc,
                                                         req_jump_target, req_cond_bits));
         pending <= expected_results.size();
      end
   end

endmodule

>>> bench/tb_simd_lane_mask_stack_controller.sv
module tb_simd_lane_mask_stack_controller import slmsc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   // all block inputs start at known values
   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  start          = 1'b0;
   logic                  busy;
   logic [3:0]            req_kind        = '0;
   logic [PC_W-1:0]       req_cur_pc      = '0;
   logic [TARGET_W-1:0]   req_jump_target = '0;
   logic [COND_W-1:0]     req_cond_bits   = '0;
   logic                  rsp_strobe;
   logic [TARGET_W-1:0]   rsp_next_pc;
   logic [COND_W-1:0]     rsp_active_mask;
   logic                  rsp_any_live;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  csr_write_en    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index       = '0;
   logic [CSR_DATA_W-1:0] csr_write_data  = '0;

   // from the checker
   int mismatch_count;
   int pending;
   int checked_count;
   int error_count;

   // sender pacing
   int issued_count = 0;
   int burst_left   = 0;
   bit steady       = 1'b1;   // no gaps while set

   always #5 clock = ~clock;

   simd_lane_mask_stack_controller dut (.*);

   lane_mask_checker lane_check (.*);

   // hard stop: far beyond the slowest legal run
   initial begin
      #5ms;
      $display("FAIL simd_lane_mask_stack_controller");
      $finish;
   end

   // ---- field pickers ----

   function automatic logic [COND_W-1:0] pick_cond();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return $urandom() & $urandom();               // sparse lanes
         3:       return $urandom() | $urandom();               // dense lanes
         4:       return COND_W'(1) << $urandom_range(0, COND_W - 1);
         5:       return ~(COND_W'(1) << $urandom_range(0, COND_W - 1));
         default: return $urandom();
      endcase
   endfunction

   // mostly in program range, sometimes past the end to hit saturation
   function automatic logic [TARGET_W-1:0] pick_target();
      if ($urandom_range(0, 9) == 0) return TARGET_W'($urandom_range(4096, 8191));
      return TARGET_W'($urandom_range(0, 4096));
   endfunction

   function automatic logic [PC_W-1:0] pick_pc();
      return PC_W'($urandom_range(0, 4095));
   endfunction

   // ---- transactions ----

   // One instruction transaction; unless steady, gaps fall between and within
   // random-length bursts. With gap 0, start stays high straight through the accepting edge.
   task automatic issue(input logic [3:0] kind, input logic [PC_W-1:0] pc,
                        input logic [TARGET_W-1:0] tgt, input logic [COND_W-1:0] cond);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (!steady) gap = $urandom_range(1, 15);
      end else if (!steady && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 3);
      end
      burst_left--;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_kind        <= kind;
      req_cur_pc      <= pc;
      req_jump_target <= tgt;
      req_cond_bits   <= cond;
      // accepted at the first edge that sees busy low
      do @(posedge clock); while (busy);
      issued_count++;
   endtask

   // Hold off until every outstanding transaction has answered, then let the
   // longest clearing pass (return with full stacks) run out.
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0 || busy);
      repeat (32) @(posedge clock);
   endtask

   // Register write; leaves a low cycle so back-to-back writes never
   // lower and raise the enable in one step.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // ---- structured programs ----

   // A start followed by nested branch and loop blocks with random content.
   // Nesting past the stack depths on purpose reaches overflow; a few noise
   // transactions (any kind but start, random fields) break the structure.
   task automatic run_program(input int len, input int max_nest, input int push_bias);
      int nest_loop [24];   // 1 = loop block, 0 = branch block
      int depth;
      int loops_open;
      int pick;
      logic [COND_W-1:0] c;
      depth      = 0;
      loops_open = 0;
      issue(K_START, pick_pc(), pick_target(), pick_cond());
      for (int n = 0; n < len; n++) begin
         pick = $urandom_range(0, 99);
         c    = pick_cond();
         if (pick < 5) begin
            issue(4'($urandom_range(1, 15)), pick_pc(), pick_target(), c);
         end else if (pick < 5 + push_bias && depth < max_nest) begin
            if ($urandom_range(0, 2) == 0) begin
               issue(K_LOOP, pick_pc(), pick_target(), c);
               nest_loop[depth] = 1;
               loops_open++;
            end else begin
               issue($urandom_range(0, 1) ? K_MASK : K_MASK_NOT, pick_pc(), pick_target(), c);
               nest_loop[depth] = 0;
            end
            depth++;
         end else if (depth > 0 && pick < 80) begin
            if (nest_loop[depth-1] == 1) begin
               // body of the innermost loop
               case ($urandom_range(0, 5))
                  0:       issue(K_LOOP_TEST, pick_pc(), pick_target(), c);
                  1:       issue(K_LOOP_RESTORE, pick_pc(), pick_target(), c);
                  2:       issue(K_LOOP_END, pick_pc(), pick_target(), c);
                  3:       issue(K_BREAK, pick_pc(), pick_target(), c);
                  4:       issue(K_CONTINUE, pick_pc(), pick_target(), c);
                  default: issue(K_PLAIN, pick_pc(), pick_target(), c);
               endcase
            end else begin
               // body of the innermost branch
               case ($urandom_range(0, 4))
                  0: issue(K_PLAIN, pick_pc(), pick_target(), c);
                  1: issue(K_JUMP_IF_ZERO, pick_pc(), pick_target(), c);
                  2: issue(loops_open > 0 ? K_BREAK : K_JUMP, pick_pc(), pick_target(), c);
                  3: issue(loops_open > 0 ? K_CONTINUE : K_PLAIN, pick_pc(), pick_target(), c);
                  default: begin
                     // else side of the branch
                     issue(K_POP_MASK, pick_pc(), pick_target(), c);
                     issue(K_MASK_NOT, pick_pc(), pick_target(), c);
                  end
               endcase
            end
         end else if (depth > 0 && pick < 92) begin
            depth--;
            if (nest_loop[depth] == 1) begin
               issue(K_LOOP_END, pick_pc(), pick_target(), c);
               issue(K_POP_LOOP, pick_pc(), pick_target(), c);
               loops_open--;
            end else begin
               issue(K_POP_MASK, pick_pc(), pick_target(), c);
            end
         end else begin
            case ($urandom_range(0, 9))
               0:       issue(K_RETURN, pick_pc(), pick_target(), c);
               1, 2:    issue(K_JUMP, pick_pc(), pick_target(), c);
               3, 4:    issue(K_JUMP_IF_ZERO, pick_pc(), pick_target(), c);
               default: issue(K_PLAIN, pick_pc(), pick_target(), c);
            endcase
         end
      end
   endtask

   // One register setting: drain, write both registers if do_write is set, then
   // run programs until the phase's share of transactions has gone out.
   task automatic run_phase(input bit do_write, input logic [CSR_DATA_W-1:0] lanes,
                            input logic [CSR_DATA_W-1:0] limit, input int items);
      int goal;
      drain();
      if (do_write) begin
         write_reg(CSR_LANE_COUNT, lanes);
         write_reg(CSR_STEP_LIMIT, limit);
      end
      goal = issued_count + items;
      while (issued_count < goal) begin
         steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) == 0) drain();
         run_program($urandom_range(8, 60), $urandom_range(2, 24), $urandom_range(20, 45));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty stacks before any start, then a start and every other kind but plain at least once
      steady = 1'b1;
      issue(K_PLAIN, 12'd4095, 13'd0, '0);              // pc steps to end, top reads 0
      issue(K_POP_MASK, 12'd10, 13'd0, '1);             // underflow
      issue(K_LOOP_TEST, 12'd11, 13'd0, '1);            // loop op with no loop
      issue(K_BREAK, 12'd12, 13'd0, '1);                // break outside loop
      issue(4'hF, 12'd13, 13'd8191, '1);                // unused code acts as plain
      issue(K_START, 12'd0, 13'd0, '0);
      issue(K_JUMP, 12'd1, 13'd8191, '0);               // target saturates
      issue(K_JUMP_IF_ZERO, 12'd2, 13'd0, 32'hFFFF_FFFE);
      issue(K_JUMP_IF_ZERO, 12'd3, 13'd100, 32'h0000_0001);
      issue(K_MASK, 12'd4, 13'd77, '0);                 // no lanes left: skip
      issue(K_POP_MASK, 12'd5, 13'd0, '0);
      issue(K_MASK_NOT, 12'd6, 13'd4096, '0);
      issue(K_LOOP, 12'd7, 13'd200, '0);
      issue(K_LOOP_TEST, 12'd8, 13'd0, 32'hFFFF_0000);
      issue(K_CONTINUE, 12'd9, 13'd0, '0);
      issue(K_LOOP_RESTORE, 12'd10, 13'd0, '0);
      issue(K_BREAK, 12'd11, 13'd0, '0);
      issue(K_LOOP_END, 12'd12, 13'd50, '0);            // loop empty: exit pc
      issue(K_POP_LOOP, 12'd13, 13'd0, '0);
      issue(K_CONTINUE, 12'd14, 13'd0, '0);             // continue outside loop
      issue(K_MASK, 12'd15, 13'd0, 32'h5555_5555);
      issue(K_RETURN, 12'd16, 13'd0, '0);
      issue(K_POP_MASK, 12'd17, 13'd0, '0);
      issue(K_POP_MASK, 12'd18, 13'd0, '0);             // leaves one mask on the stack
      issue(K_POP_LOOP, 12'd19, 13'd0, '0);             // underflow, no loop

      // random: reset registers first, then extremes and mid settings
      run_phase(1'b0, '0, '0, 300);
      run_phase(1'b1, 24'd1, 24'hFF_FFFF, 250);
      run_phase(1'b1, 24'd0, 24'd40, 250);
      run_phase(1'b1, CSR_DATA_W'({$urandom(), 6'd63}), 24'd1, 100);  // junk above lane bits
      run_phase(1'b1, CSR_DATA_W'($urandom_range(2, 31)), CSR_DATA_W'($urandom_range(20, 200)),
                300);
      run_phase(1'b1, 24'd32, 24'd0, 60);
      run_phase(1'b1, 24'd32, STEP_LIMIT_RESET, 250);
      drain();

      $display("Sent %0d control transactions over seven register settings", issued_count);
      $display("(lane counts 0..63, step limits 0..max): %0d results checked, %0d errors flagged",
               checked_count, error_count);
      if (mismatch_count == 0 && pending == 0)
         $display("PASS simd_lane_mask_stack_controller");
      else
         $display("FAIL simd_lane_mask_stack_controller");
      $finish;
   end

endmodule

>>> filelist.f
sv/slmsc_pkg.sv
sv/simd_lane_mask_stack_controller.sv
sv/slmsc_checker.sv
bench/lane_mask_checker.sv
bench/tb_simd_lane_mask_stack_controller.sv
